@@ rtl/pva_pkg.sv @@
package pva_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STAGES       = 24;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [29:0] KGAIN     = 30'd652032874;
  localparam int          FULL_TURN = 46080;
  localparam int          DEG90     = 5898240;
  localparam int          DEG180    = 11796480;
  localparam int          DEG270    = 17694720;
  localparam int          DEG360    = 23592960;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_CROSS = 2'd2,
    OP_MOVE  = 2'd3
  } pva_op_t;

  // classified item handed from the front to the back
  typedef struct packed {
    pva_op_t            op;
    logic [23:0]        range_a;
    logic signed [25:0] z_a;
    logic               neg_a;
    logic [23:0]        range_b;
    logic signed [25:0] z_b;
    logic               neg_b;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } pva_item_t;

  // arctangent of 2^-i in 1/65536 degree
  function automatic int atan_val(input int i);
    int v;
    case (i)
      0:  v = 2949120;
      1:  v = 1740967;
      2:  v = 919879;
      3:  v = 466945;
      4:  v = 234379;
      5:  v = 117304;
      6:  v = 58666;
      7:  v = 29335;
      8:  v = 14668;
      9:  v = 7334;
      10: v = 3667;
      11: v = 1833;
      12: v = 917;
      13: v = 458;
      14: v = 229;
      15: v = 115;
      16: v = 57;
      17: v = 29;
      18: v = 14;
      19: v = 7;
      20: v = 4;
      21: v = 2;
      22: v = 1;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pva_front.sv @@
module pva_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pva_pkg::pva_op_t    op,
  input  logic [23:0]         range_a,
  input  logic [15:0]         angle_a,
  input  logic [23:0]         range_b,
  input  logic [15:0]         angle_b,
  input  logic signed [23:0]  pos_x,
  input  logic signed [23:0]  pos_y,
  input  logic                q_full,
  output logic                q_push,
  output pva_pkg::pva_item_t  q_item
);

  logic               fr_valid_r, fr_valid_nxt;
  pva_pkg::pva_item_t fr_item_r, fr_item_nxt;
  logic signed [25:0] za, zb;
  logic               na, nb;

  // reduce heading to one turn, scale to 1/65536 degree, fold into +-90
  function automatic logic [26:0] fold(input logic [15:0] ang);
    logic [15:0]        a;
    logic signed [25:0] z;
    logic               n;
    a = ang;
    if (a >= 16'(pva_pkg::FULL_TURN)) a = a - 16'(pva_pkg::FULL_TURN);
    z = $signed({1'b0, a, 9'd0});
    n = 1'b0;
    if (z > 26'sd5898240 && z <= 26'(pva_pkg::DEG270)) begin
      z = z - 26'(pva_pkg::DEG180);
      n = 1'b1;
    end else if (z > 26'(pva_pkg::DEG270)) begin
      z = z - 26'(pva_pkg::DEG360);
    end
    return {n, z};
  endfunction

  always_comb begin
    {na, za} = fold(angle_a);
    {nb, zb} = fold(angle_b);
    fr_item_nxt.op      = op;
    fr_item_nxt.range_a = range_a;
    fr_item_nxt.z_a     = za;
    fr_item_nxt.neg_a   = na;
    fr_item_nxt.range_b = range_b;
    fr_item_nxt.z_b     = zb;
    fr_item_nxt.neg_b   = nb;
    fr_item_nxt.pos_x   = pos_x;
    fr_item_nxt.pos_y   = pos_y;
  end

  assign in_stall     = fr_valid_r && q_full;
  assign q_push       = fr_valid_r && !q_full;
  assign q_item       = fr_item_r;
  assign fr_valid_nxt = in_stall ? fr_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      fr_item_r <= fr_item_nxt;
    end
  end

endmodule

@@ rtl/pva_queue.sv @@
module pva_queue #(
  parameter int DEPTH = pva_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pva_pkg::pva_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output pva_pkg::pva_item_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pva_pkg::pva_item_t mem_r [DEPTH];
  logic [PW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [PW:0]        count_r;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == (PW + 1)'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/pva_back.sv @@
module pva_back #(
  parameter int CORDIC_STEPS = pva_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  pva_pkg::pva_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        out_range_out,
  output logic [15:0]        out_angle_out,
  output logic signed [31:0] out_cross_out,
  output logic signed [23:0] out_x_out,
  output logic signed [23:0] out_y_out
);

  localparam int N = (CORDIC_STEPS > pva_pkg::MAX_STAGES) ? pva_pkg::MAX_STAGES : CORDIC_STEPS;
  localparam int L = 2 * N + 7;

  typedef struct packed {
    pva_pkg::pva_op_t   op;
    logic               neg_a;
    logic               neg_b;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } rot_side_t;

  typedef struct packed {
    pva_pkg::pva_op_t   op;
    logic               base;
    logic signed [31:0] cprod;
    logic signed [23:0] px;
    logic signed [23:0] py;
  } vec_side_t;

  logic         adv;
  logic [L-1:0] vld_r;

  assign adv       = !(vld_r[L-1] && out_stall);
  assign q_pop     = adv && q_valid;
  assign out_valid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], q_pop};
    end
  end

  // gain correction multiply
  logic [53:0]        m_a_r, m_b_r;
  logic signed [25:0] m_za_r, m_zb_r;
  rot_side_t          m_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_a_r    <= 54'(q_item.range_a) * 54'(pva_pkg::KGAIN);
      m_b_r    <= 54'(q_item.range_b) * 54'(pva_pkg::KGAIN);
      m_za_r   <= q_item.z_a;
      m_zb_r   <= q_item.z_b;
      m_side_r <= '{op: q_item.op, neg_a: q_item.neg_a, neg_b: q_item.neg_b,
                    pos_x: q_item.pos_x, pos_y: q_item.pos_y};
    end
  end

  // rotation CORDIC, both vectors side by side
  logic signed [35:0] rxa_r [N+1];
  logic signed [35:0] rya_r [N+1];
  logic signed [25:0] rza_r [N+1];
  logic signed [35:0] rxb_r [N+1];
  logic signed [35:0] ryb_r [N+1];
  logic signed [25:0] rzb_r [N+1];
  rot_side_t          rs_r  [N+1];
  logic [53:0]        ma_rnd, mb_rnd;

  assign ma_rnd = m_a_r + 54'd2097152;
  assign mb_rnd = m_b_r + 54'd2097152;

  always_ff @(posedge clk) begin
    if (adv) begin
      rxa_r[0] <= $signed({4'd0, ma_rnd[53:22]});
      rya_r[0] <= '0;
      rza_r[0] <= m_za_r;
      rxb_r[0] <= $signed({4'd0, mb_rnd[53:22]});
      ryb_r[0] <= '0;
      rzb_r[0] <= m_zb_r;
      rs_r[0]  <= m_side_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [25:0] AT = 26'(pva_pkg::atan_val(i));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!rza_r[i][25]) begin
          rxa_r[i+1] <= rxa_r[i] - (rya_r[i] >>> i);
          rya_r[i+1] <= rya_r[i] + (rxa_r[i] >>> i);
          rza_r[i+1] <= rza_r[i] - AT;
        end else begin
          rxa_r[i+1] <= rxa_r[i] + (rya_r[i] >>> i);
          rya_r[i+1] <= rya_r[i] - (rxa_r[i] >>> i);
          rza_r[i+1] <= rza_r[i] + AT;
        end
        if (!rzb_r[i][25]) begin
          rxb_r[i+1] <= rxb_r[i] - (ryb_r[i] >>> i);
          ryb_r[i+1] <= ryb_r[i] + (rxb_r[i] >>> i);
          rzb_r[i+1] <= rzb_r[i] - AT;
        end else begin
          rxb_r[i+1] <= rxb_r[i] + (ryb_r[i] >>> i);
          ryb_r[i+1] <= ryb_r[i] - (rxb_r[i] >>> i);
          rzb_r[i+1] <= rzb_r[i] + AT;
        end
        rs_r[i+1] <= rs_r[i];
      end
    end
  end

  // unfold and round to Q.8
  function automatic logic signed [25:0] to_q8(input logic signed [35:0] v,
                                               input logic neg);
    logic signed [35:0] t;
    t = neg ? -v : v;
    t = (t + 36'sd128) >>> 8;
    return t[25:0];
  endfunction

  logic signed [25:0] ax_r, ay_r, bx_r, by_r;
  rot_side_t          c_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax_r     <= to_q8(rxa_r[N], rs_r[N].neg_a);
      ay_r     <= to_q8(rya_r[N], rs_r[N].neg_a);
      bx_r     <= to_q8(rxb_r[N], rs_r[N].neg_b);
      by_r     <= to_q8(ryb_r[N], rs_r[N].neg_b);
      c_side_r <= rs_r[N];
    end
  end

  // combine: products, sum or difference, moved point
  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607)       return 24'sh7FFFFF;
    else if (v < -27'sd8388608) return 24'sh800000;
    else                        return v[23:0];
  endfunction

  logic signed [51:0] pa_r, pb_r;
  logic signed [26:0] sx_r, sy_r;
  logic signed [23:0] d_px_r, d_py_r;
  pva_pkg::pva_op_t   d_op_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= 52'(ax_r) * 52'(by_r);
      pb_r <= 52'(ay_r) * 52'(bx_r);
      if (c_side_r.op == pva_pkg::OP_SUB) begin
        sx_r <= 27'(ax_r) - 27'(bx_r);
        sy_r <= 27'(ay_r) - 27'(by_r);
      end else begin
        sx_r <= 27'(ax_r) + 27'(bx_r);
        sy_r <= 27'(ay_r) + 27'(by_r);
      end
      d_px_r <= sat24(27'(c_side_r.pos_x) + 27'(bx_r));
      d_py_r <= sat24(27'(c_side_r.pos_y) + 27'(by_r));
      d_op_r <= c_side_r.op;
    end
  end

  // cross product rounded up, and fold into right half plane
  logic signed [52:0] cr_d;
  logic signed [36:0] cr_c;
  logic signed [31:0] cr_sat;
  logic               fold_neg;
  logic signed [26:0] fx, fy;

  always_comb begin
    cr_d = 53'(pa_r) - 53'(pb_r);
    cr_c = 37'((cr_d + 53'sd65535) >>> 16);
    if (cr_c > 37'sd2147483647)       cr_sat = 32'sh7FFFFFFF;
    else if (cr_c < -37'sd2147483648) cr_sat = 32'sh80000000;
    else                              cr_sat = cr_c[31:0];
    fold_neg = sx_r[26];
    fx = fold_neg ? -sx_r : sx_r;
    fy = fold_neg ? -sy_r : sy_r;
  end

  logic signed [37:0] vx_r [N+1];
  logic signed [37:0] vy_r [N+1];
  logic signed [25:0] vz_r [N+1];
  vec_side_t          vs_r [N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r[0] <= {3'(fx[26] ? 3'b111 : 3'b000), fx, 8'd0};
      vy_r[0] <= {3'(fy[26] ? 3'b111 : 3'b000), fy, 8'd0};
      vz_r[0] <= '0;
      vs_r[0] <= '{op: d_op_r, base: fold_neg, cprod: cr_sat, px: d_px_r, py: d_py_r};
    end
  end

  // vectoring CORDIC
  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [25:0] AT = 26'(pva_pkg::atan_val(i));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!vy_r[i][37]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + AT;
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - AT;
        end
        vs_r[i+1] <= vs_r[i];
      end
    end
  end

  // gain correction and heading
  logic [36:0]        ux;
  logic [45:0]        lo_k;
  logic signed [27:0] asum;
  logic signed [18:0] aq;
  logic [15:0]        awrap;

  always_comb begin
    ux   = vx_r[N][37] ? '0 : vx_r[N][36:0];
    lo_k = 46'(ux[15:0]) * 46'(pva_pkg::KGAIN);
    asum = 28'(vz_r[N]) + 28'sd256 + (vs_r[N].base ? 28'(pva_pkg::DEG180) : 28'sd0);
    aq   = 19'(asum >>> 9);
    if (aq[18])                          awrap = 16'(aq + 19'(pva_pkg::FULL_TURN));
    else if (aq >= 19'(pva_pkg::FULL_TURN)) awrap = 16'(aq - 19'(pva_pkg::FULL_TURN));
    else                                 awrap = aq[15:0];
  end

  logic [50:0] f_hk_r;
  logic [29:0] f_lk_r;
  logic [15:0] f_ang_r;
  vec_side_t   f_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_hk_r   <= 51'(ux[36:16]) * 51'(pva_pkg::KGAIN);
      f_lk_r   <= lo_k[45:16];
      f_ang_r  <= awrap;
      f_side_r <= vs_r[N];
    end
  end

  logic [51:0] t_sum;
  logic [29:0] r_full;
  logic [23:0] r_sat;

  always_comb begin
    t_sum  = 52'(f_hk_r) + 52'(f_lk_r) + 52'd2097152;
    r_full = t_sum[51:22];
    r_sat  = (r_full[29:24] != '0) ? 24'hFFFFFF : r_full[23:0];
  end

  // select the fields the op produces, zero the rest
  logic [23:0]        o_range;
  logic [15:0]        o_angle;
  logic signed [31:0] o_cprod;
  logic signed [23:0] o_x, o_y;

  always_comb begin
    o_range = '0;
    o_angle = '0;
    o_cprod = '0;
    o_x     = '0;
    o_y     = '0;
    unique case (f_side_r.op) inside
      pva_pkg::OP_ADD, pva_pkg::OP_SUB: begin
        o_range = r_sat;
        o_angle = (r_sat == '0) ? 16'd0 : f_ang_r;
      end
      pva_pkg::OP_CROSS: begin
        o_cprod = f_side_r.cprod;
      end
      default: begin
        o_x = f_side_r.px;
        o_y = f_side_r.py;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_range_out <= o_range;
      out_angle_out <= o_angle;
      out_cross_out <= o_cprod;
      out_x_out     <= o_x;
      out_y_out     <= o_y;
    end
  end

endmodule

@@ rtl/polar_vector_arith_top.sv @@
// Polar vector arithmetic unit.
// Input channel (in_valid / in_stall): an op and two polar vectors (length
// Q16.8, heading in 1/128 degree) plus a point in Q15.8. Op add and op
// subtract give length and heading of a+b or a-b; op cross gives the cross
// product rounded up; op move gives the point offset by vector b.
// Result channel (out_valid / out_stall): one result item per input item,
// in order; fields an op does not produce are zero.
// Throughput: one item per cycle while out_stall is low. N = min(CORDIC_STEPS,
// 24) sets the depth of the two N-stage CORDIC pipelines (rotation, then
// vectoring) that lie between input accept and out_valid.
// A front register classifies each item and feeds a 4-entry queue; the back
// pipeline drains the queue. When out_stall is high with a result waiting,
// the whole back pipeline holds and the queue fills; in_stall rises only
// when the front register holds an item and the queue is full.
// Reset (rst_n low, synchronous) empties the front register, the queue and
// all pipeline valid bits; no result is presented until new items arrive.
module polar_vector_arith_top #(
  parameter int CORDIC_STEPS = pva_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [23:0]        in_range_a,
  input  logic [15:0]        in_angle_a,
  input  logic [23:0]        in_range_b,
  input  logic [15:0]        in_angle_b,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        out_range_out,
  output logic [15:0]        out_angle_out,
  output logic signed [31:0] out_cross_out,
  output logic signed [23:0] out_x_out,
  output logic signed [23:0] out_y_out
);

  logic               q_push, q_full, q_pop, q_valid;
  pva_pkg::pva_item_t q_in, q_head;

  pva_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (pva_pkg::pva_op_t'(in_op)),
    .range_a  (in_range_a),
    .angle_a  (in_angle_a),
    .range_b  (in_range_b),
    .angle_b  (in_angle_b),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  pva_queue #(
    .DEPTH (pva_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  pva_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_range_out (out_range_out),
    .out_angle_out (out_angle_out),
    .out_cross_out (out_cross_out),
    .out_x_out     (out_x_out),
    .out_y_out     (out_y_out)
  );

endmodule
